// File: hdl/apr_pkg.sv
// Shared constants, types and helpers for the aging page replacement unit.
package apr_pkg;

    // Table geometry
    localparam int FRAMES    = 16;
    localparam int AGE_BITS  = 32;
    localparam int PAGE_BITS = 16;

    // Fixed port widths
    localparam int IN_PAGE_W = 16;
    localparam int OUT_IDX_W = 4;
    localparam int CFG_W     = 5;
    localparam int MISS_W    = 32;

    localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    // Minimum-age search: first stage reduces groups of GROUP frames
    localparam int GROUP   = 4;
    localparam int NGROUPS = (FRAMES + GROUP - 1) / GROUP;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
    localparam logic [MISS_W-1:0] MISS_MAX = {MISS_W{1'b1}};

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [AGE_BITS-1:0]  age_t;
    typedef logic [IDX_W-1:0]     idx_t;

    localparam age_t AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};
    localparam age_t AGE_LOW = {1'b0, {(AGE_BITS-1){1'b1}}};

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming page
        logic look;     // register compare results and group minimums
        logic commit;   // update the table and load the result register
    } cmd_t;

    // Input page field to internal page width
    function automatic page_t to_page(input logic [IN_PAGE_W-1:0] p);
        page_t r;
        r = '0;
        for (int b = 0; b < PAGE_BITS && b < IN_PAGE_W; b++) r[b] = p[b];
        return r;
    endfunction

    // Internal page to output field width
    function automatic logic [IN_PAGE_W-1:0] to_out_page(input page_t p);
        logic [IN_PAGE_W-1:0] r;
        r = '0;
        for (int b = 0; b < PAGE_BITS && b < IN_PAGE_W; b++) r[b] = p[b];
        return r;
    endfunction

    // Frame index to output field width (low bits)
    function automatic logic [OUT_IDX_W-1:0] to_out_idx(input idx_t i);
        logic [OUT_IDX_W-1:0] r;
        r = '0;
        for (int b = 0; b < OUT_IDX_W && b < IDX_W; b++) r[b] = i[b];
        return r;
    endfunction

endpackage

// File: hdl/apr_ctrl.sv
// Controller: sequences each item through look and pick, owns the output valid.
module apr_ctrl
    import apr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_PICK
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_commit;
    logic   in_acc;

    // Commit once the result register is free or being emptied
    assign can_commit = (state_reg == S_PICK) && (!out_valid_reg || out_ready);
    assign in_ready   = (state_reg == S_IDLE) || can_commit;
    assign in_acc     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;

    assign cmd.capture = in_acc;
    assign cmd.look    = (state_reg == S_LOOK);
    assign cmd.commit  = can_commit;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_acc) state_next = S_LOOK;
            S_LOOK: state_next = S_PICK;
            S_PICK:
            begin
                if (can_commit) state_next = in_acc ? S_LOOK : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output valid: set on commit, cleared when taken
    always_comb
    begin
        if (can_commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/apr_datapath.sv
// Datapath: frame table, tag compare, two-stage minimum-age search, result register.
module apr_datapath
    import apr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic [IN_PAGE_W-1:0] page_number,
    output logic                 hit,
    output logic [OUT_IDX_W-1:0] frame_index,
    output logic                 evicted_valid,
    output logic [IN_PAGE_W-1:0] evicted_page,
    output logic [MISS_W-1:0]    miss_count
);

    // Frame table and counters
    page_t             pages_reg [FRAMES];
    logic [FRAMES-1:0] valid_reg, valid_next;
    age_t              ages_reg  [FRAMES];
    age_t              ages_next [FRAMES];
    logic [MISS_W-1:0] misses_reg, misses_next;
    logic [CFG_W-1:0]  frames_in_use_reg;

    // Look stage registers
    page_t  page_reg;
    logic   hit_found_reg, empty_found_reg;
    idx_t   hit_idx_reg, empty_idx_reg;
    age_t   grp_age_reg [NGROUPS];
    idx_t   grp_idx_reg [NGROUPS];
    logic   grp_act_reg [NGROUPS];

    // Result register
    logic                 hit_out_reg, ev_valid_out_reg;
    logic [OUT_IDX_W-1:0] idx_out_reg;
    logic [IN_PAGE_W-1:0] ev_page_out_reg;
    logic [MISS_W-1:0]    miss_out_reg;

    // Look stage logic
    logic [FRAMES-1:0] active, match, empty;
    logic hit_found, empty_found;
    idx_t hit_idx, empty_idx;
    age_t grp_age [NGROUPS];
    idx_t grp_idx [NGROUPS];
    logic grp_act [NGROUPS];

    // Pick stage logic
    logic best_found;
    age_t best_age;
    idx_t best_idx, slot;
    logic evict;

    // Tag compare, empty detect and priority encode over active frames
    always_comb
    begin
        hit_found   = 1'b0;
        empty_found = 1'b0;
        hit_idx     = '0;
        empty_idx   = '0;
        for (int k = 0; k < FRAMES; k++)
        begin
            active[k] = (k == 0) || (int'(frames_in_use_reg) > k);
            match[k]  = active[k] && valid_reg[k] && (pages_reg[k] == page_reg);
            empty[k]  = active[k] && !valid_reg[k];
        end
        for (int k = FRAMES - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                hit_found = 1'b1;
                hit_idx   = idx_t'(k);
            end
            if (empty[k])
            begin
                empty_found = 1'b1;
                empty_idx   = idx_t'(k);
            end
        end
    end

    // First level of the minimum search: smallest age per group, lowest index on ties
    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            grp_act[g] = 1'b0;
            grp_age[g] = '0;
            grp_idx[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                if (g * GROUP + j < FRAMES)
                begin
                    if (active[g * GROUP + j] &&
                        (!grp_act[g] || ages_reg[g * GROUP + j] < grp_age[g]))
                    begin
                        grp_act[g] = 1'b1;
                        grp_age[g] = ages_reg[g * GROUP + j];
                        grp_idx[g] = idx_t'(g * GROUP + j);
                    end
                end
            end
        end
    end

    // Second level of the minimum search across groups
    always_comb
    begin
        best_found = 1'b0;
        best_age   = '0;
        best_idx   = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            if (grp_act_reg[g] && (!best_found || grp_age_reg[g] < best_age))
            begin
                best_found = 1'b1;
                best_age   = grp_age_reg[g];
                best_idx   = grp_idx_reg[g];
            end
        end
    end

    // Slot choice: hit, else first empty frame, else oldest frame
    assign evict = !hit_found_reg && !empty_found_reg;
    always_comb
    begin
        if (hit_found_reg)
            slot = hit_idx_reg;
        else if (empty_found_reg)
            slot = empty_idx_reg;
        else
            slot = best_idx;
    end

    // Table update: age every frame, then mark the touched one
    always_comb
    begin
        valid_next  = valid_reg;
        misses_next = misses_reg;
        for (int k = 0; k < FRAMES; k++) ages_next[k] = ages_reg[k] >> 1;
        if (hit_found_reg)
        begin
            ages_next[slot] = (ages_reg[slot] >> 1) | AGE_TOP;
        end
        else
        begin
            ages_next[slot]  = AGE_LOW;
            valid_next[slot] = 1'b1;
            if (misses_reg != MISS_MAX) misses_next = misses_reg + 1'b1;
        end
    end

    // Control state, ages and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= '0;
            misses_reg        <= '0;
            frames_in_use_reg <= CFG_RESET;
            for (int k = 0; k < FRAMES; k++) ages_reg[k] <= '0;
        end
        else
        begin
            if (cfg_wr_en) frames_in_use_reg <= cfg_wr_data;
            if (cmd.commit)
            begin
                valid_reg  <= valid_next;
                misses_reg <= misses_next;
                for (int k = 0; k < FRAMES; k++) ages_reg[k] <= ages_next[k];
            end
        end
    end

    // Payload registers: pages, look stage, result
    always_ff @(posedge clk)
    begin
        if (cmd.capture) page_reg <= to_page(page_number);
        if (cmd.look)
        begin
            hit_found_reg   <= hit_found;
            hit_idx_reg     <= hit_idx;
            empty_found_reg <= empty_found;
            empty_idx_reg   <= empty_idx;
            for (int g = 0; g < NGROUPS; g++)
            begin
                grp_age_reg[g] <= grp_age[g];
                grp_idx_reg[g] <= grp_idx[g];
                grp_act_reg[g] <= grp_act[g];
            end
        end
        if (cmd.commit)
        begin
            if (!hit_found_reg) pages_reg[slot] <= page_reg;
            hit_out_reg      <= hit_found_reg;
            idx_out_reg      <= to_out_idx(slot);
            ev_valid_out_reg <= evict;
            ev_page_out_reg  <= evict ? to_out_page(pages_reg[slot]) : '0;
            miss_out_reg     <= misses_next;
        end
    end

    assign hit           = hit_out_reg;
    assign frame_index   = idx_out_reg;
    assign evicted_valid = ev_valid_out_reg;
    assign evicted_page  = ev_page_out_reg;
    assign miss_count    = miss_out_reg;

endmodule

// File: hdl/aging_page_replacement_unit.sv
// Top level of the aging page replacement unit.
//
// One item on the input channel (in_valid/in_ready) is one page reference,
// page_number. For each item exactly one result leaves on the output channel
// (out_valid/out_ready): hit, frame_index, evicted_valid, evicted_page and
// the saturating miss_count after this reference.
// An accepted item passes the look step and then the pick step; the tag
// compare and the first level of the minimum-age search are registered in
// the look cycle, the second level, slot choice and table write-back take
// the pick cycle, and the next item is taken in that same pick cycle once
// the result commits. The result sits in an output register; while the
// receiver stalls, one further item is still taken and held at the pick
// step until the output register frees up.
// Reset clears all valid marks, ages, the miss count and the output valid,
// and sets frames_in_use to 16. cfg_wr_en/cfg_wr_data write frames_in_use
// (0 acts as 1, above 16 acts as 16); write it only while the unit is idle.
module aging_page_replacement_unit
    import apr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IN_PAGE_W-1:0] page_number,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [OUT_IDX_W-1:0] frame_index,
    output logic                 evicted_valid,
    output logic [IN_PAGE_W-1:0] evicted_page,
    output logic [MISS_W-1:0]    miss_count
);

    cmd_t cmd;

    apr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    apr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .page_number   (page_number),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .miss_count    (miss_count)
    );

endmodule

// File: hdl/apr_checker.sv
// Port-level checks for the aging page replacement unit, bound to the top level.
module apr_checker
    import apr_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 hit,
    input logic [OUT_IDX_W-1:0] frame_index,
    input logic                 evicted_valid,
    input logic [IN_PAGE_W-1:0] evicted_page,
    input logic [MISS_W-1:0]    miss_count
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(frame_index)
            && $stable(evicted_valid) && $stable(evicted_page) && $stable(miss_count))
        else $error("result changed while stalled");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !evicted_valid)
        else $error("hit reported an eviction");

    // No eviction reports page zero
    a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    // Items are never taken back to back
    a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken in back-to-back cycles");

endmodule

bind aging_page_replacement_unit apr_checker u_apr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .miss_count    (miss_count)
);

// File: sim/testbench.sv
// Self-checking testbench for the aging page replacement unit.
module testbench;
    import apr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int STALL_CYCLES   = 300;
    localparam int REPORT_MAX     = 10;

    // One lookup outcome as seen on the result channel
    typedef struct packed {
        logic                 hit;
        logic [OUT_IDX_W-1:0] frame;
        logic                 ev_valid;
        logic [IN_PAGE_W-1:0] ev_page;
        logic [MISS_W-1:0]    misses;
    } lookup_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [IN_PAGE_W-1:0] page_number = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 hit;
    logic [OUT_IDX_W-1:0] frame_index;
    logic                 evicted_valid;
    logic [IN_PAGE_W-1:0] evicted_page;
    logic [MISS_W-1:0]    miss_count;

    // Page references waiting to be offered, and lookups waiting to come out
    logic [IN_PAGE_W-1:0] pending_pages [$];
    lookup_result_t       expected_lookups [$];

    // Shadow copy of the frame table
    page_t             shadow_page [FRAMES];
    logic              shadow_valid [FRAMES];
    age_t              shadow_age [FRAMES];
    logic [MISS_W-1:0] shadow_misses;
    logic [CFG_W-1:0]  frames_cfg;

    int mismatches   = 0;
    int results_seen = 0;
    int in_idle_pct  = 16;
    int out_idle_pct = 16;
    int stall_left   = 0;
    bit stall_done   = 1'b0;
    int quiet_cycles = 0;

    aging_page_replacement_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .page_number   (page_number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit),
        .frame_index   (frame_index),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .miss_count    (miss_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shift every age right by one, active or not
    task automatic age_table();
        for (int k = 0; k < FRAMES; k++)
            shadow_age[k] = shadow_age[k] >> 1;
    endtask

    // Look up one page in the shadow table, update it, queue the outcome
    task automatic apply_reference(input logic [IN_PAGE_W-1:0] raw);
        page_t          pg;
        int             n;
        int             slot;
        bit             found;
        lookup_result_t r;
        pg    = page_t'(raw);
        n     = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
        slot  = 0;
        found = 1'b0;
        r     = '0;
        // lowest active frame holding the page wins
        for (int k = 0; k < n; k++)
            if (!found && shadow_valid[k] && shadow_page[k] == pg)
            begin
                slot  = k;
                found = 1'b1;
            end
        if (found)
        begin
            r.hit = 1'b1;
            age_table();
            shadow_age[slot] = shadow_age[slot] | AGE_TOP;
        end
        else
        begin
            if (shadow_misses != MISS_MAX)
                shadow_misses = shadow_misses + 1'b1;
            // first empty active frame
            for (int k = 0; k < n; k++)
                if (!found && !shadow_valid[k])
                begin
                    slot  = k;
                    found = 1'b1;
                end
            // otherwise the lowest-indexed frame with the smallest age
            if (!found)
            begin
                slot = 0;
                for (int k = 1; k < n; k++)
                    if (shadow_age[k] < shadow_age[slot])
                        slot = k;
                r.ev_valid = 1'b1;
                r.ev_page  = IN_PAGE_W'(shadow_page[slot]);
            end
            shadow_page[slot]  = pg;
            shadow_valid[slot] = 1'b1;
            age_table();
            shadow_age[slot] = AGE_LOW;
        end
        r.frame  = OUT_IDX_W'(slot);
        r.misses = shadow_misses;
        expected_lookups.push_back(r);
    endtask

    // Driver: offers pending pages, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            page_number <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_reference(page_number);
            if (!in_valid || in_ready)
            begin
                if (pending_pages.size() != 0 && $urandom_range(0, 99) >= in_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    page_number <= pending_pages.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks results and drives out_ready, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin : monitor
        lookup_result_t want;
        lookup_result_t got;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                got = '{hit, frame_index, evicted_valid, evicted_page, miss_count};
                if (expected_lookups.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: hit=%0d frame=%0d ev=%0d %s=%h miss=%0d",
                                 got.hit, got.frame, got.ev_valid, "ev_page",
                                 got.ev_page, got.misses);
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (got.hit !== want.hit || got.frame !== want.frame ||
                        got.ev_valid !== want.ev_valid || got.ev_page !== want.ev_page ||
                        got.misses !== want.misses)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("result %0d: exp hit=%0d frame=%0d ev=%0d ev_page=%h miss=%0d",
                                     results_seen, want.hit, want.frame, want.ev_valid,
                                     want.ev_page, want.misses);
                            $display("    got hit=%0d frame=%0d ev=%0d ev_page=%h miss=%0d",
                                     got.hit, got.frame, got.ev_valid, got.ev_page,
                                     got.misses);
                        end
                    end
                end
            end
            // long hold-off while the sender still has plenty queued
            if (!stall_done && results_seen >= 500 && pending_pages.size() > 20)
            begin
                stall_left = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Wait until nothing is in flight
    task automatic wait_drained();
        while (pending_pages.size() != 0 || in_valid || expected_lookups.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write frames_in_use while the unit is idle
    task automatic set_frames(input logic [CFG_W-1:0] v);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        frames_cfg = v;
    endtask

    // Stimulus
    initial
    begin
        logic [CFG_W-1:0]     phase_cfg [13];
        logic [IN_PAGE_W-1:0] hot_pages [$];
        int                   n_act;
        int                   n_hot;
        int                   n_items;
        int                   pick;
        for (int k = 0; k < FRAMES; k++)
        begin
            shadow_page[k]  = '0;
            shadow_valid[k] = 1'b0;
            shadow_age[k]   = '0;
        end
        shadow_misses = '0;
        frames_cfg    = CFG_RESET;
        phase_cfg = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd8, 5'd31, 5'd5,
                      5'd16, 5'd2, 5'd12, 5'd17, 5'd6, 5'd16};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, hits, misses into empty frames
        pending_pages = '{16'h0000, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'hFFFF};

        // One frame: evictions, and frame 1 keeps its page while inactive
        set_frames(5'd1);
        pending_pages = '{16'h0F0F, 16'hFFFF};
        // Zero acts as one frame
        set_frames(5'd0);
        pending_pages = '{16'h8000};
        // Two frames: page FFFF hits in frame 1, then a miss evicts the oldest frame
        set_frames(5'd2);
        pending_pages = '{16'hFFFF, 16'h0001};
        // Above the table size acts as all frames: fill, then evict
        set_frames(5'd31);
        for (int k = 0; k < 13; k++)
            pending_pages.push_back(IN_PAGE_W'(16'h0100 + k));
        pending_pages.push_back(16'h0105);

        // Random phases over several frame counts
        foreach (phase_cfg[i])
        begin
            set_frames(phase_cfg[i]);
            in_idle_pct  = (i % 2 == 1) ? 0 : 16;
            out_idle_pct = (i % 2 == 1) ? 0 : 16;
            n_act = (phase_cfg[i] == 0) ? 1 :
                    ((phase_cfg[i] > FRAMES) ? FRAMES : int'(phase_cfg[i]));
            // working set of the active frame count plus up to four pages
            n_hot = n_act + int'($urandom_range(0, 4));
            hot_pages.delete();
            for (int k = 0; k < n_hot; k++)
                hot_pages.push_back(IN_PAGE_W'($urandom));
            n_items = $urandom_range(70, 106);
            for (int k = 0; k < n_items; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    pending_pages.push_back(IN_PAGE_W'($urandom));
                else if (pick < 55)
                    // skew toward the front of the set so ages differ
                    pending_pages.push_back(
                        hot_pages[$urandom_range(0, (hot_pages.size() - 1) / 2)]);
                else
                    pending_pages.push_back(
                        hot_pages[$urandom_range(0, hot_pages.size() - 1)]);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_lookups.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
